// ----- src/lsc_pkg.sv -----
// Shared types, constants and helper functions of the calibrated line sensor.
package lsc_pkg;

	localparam int CHANNELS    = 8;
	localparam int SAMPLE_BITS = 12;
	localparam int CH_W        = $clog2(CHANNELS);
	localparam int PCT_SCALE   = 100;
	localparam int PCT_W       = 7;
	localparam int VAL_W       = 10;
	localparam int POS_W       = 10;
	localparam int POS_LIMIT   = 1023;
	localparam int CFG_IDX_W   = 2;
	localparam int FIFO_DEPTH_DEF = 2;

	// sum of mapped values and weighted sum
	localparam int SUM_W  = VAL_W + $clog2(CHANNELS);
	localparam int WSUM_W = $clog2(PCT_SCALE * 1023 * CHANNELS * (CHANNELS - 1) / 2 + 1);
	// quotient bits of the centroid (weights are 0..100*(CHANNELS-1))
	localparam int QW     = $clog2(PCT_SCALE * (CHANNELS - 1) + 1);
	localparam int QR_W   = (QW > VAL_W) ? QW : VAL_W;
	localparam int DIV_W  = SUM_W + QR_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OUT_MIN = 2'd0,
		CFG_OUT_MAX = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic        mode;
		logic [11:0] sample_0;
		logic [11:0] sample_1;
		logic [11:0] sample_2;
		logic [11:0] sample_3;
		logic [11:0] sample_4;
		logic [11:0] sample_5;
		logic [11:0] sample_6;
		logic [11:0] sample_7;
	} in_t;

	typedef struct packed {
		logic [POS_W-1:0] line_position;
		logic             line_found;
	} out_t;

	typedef struct packed {
		logic [VAL_W-1:0] out_min;
		logic [VAL_W-1:0] out_max;
	} cfg_t;

	typedef struct packed {
		logic                           mode;
		logic [CHANNELS-1:0][PCT_W-1:0] pct;
	} q_entry_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MAP,
		B_DIV,
		B_ACC,
		B_FDIV,
		B_OUT
	} back_st_t;

	// raw * 100 >> SAMPLE_BITS, always 0..99
	function automatic logic [PCT_W-1:0] pct_of(input logic [SAMPLE_BITS-1:0] raw);
		logic [SAMPLE_BITS+PCT_W-1:0] p;
		p = raw * (SAMPLE_BITS+PCT_W)'(PCT_SCALE);
		return p[SAMPLE_BITS+PCT_W-1:SAMPLE_BITS];
	endfunction

	// centroid weight of a channel
	function automatic logic [QW-1:0] ch_weight(input logic [CH_W-1:0] ch);
		return QW'(PCT_SCALE * int'(ch));
	endfunction

endpackage

// ----- src/lsc_front.sv -----
// Front end: takes scans, converts samples to percent and pushes queue entries.
module lsc_front import lsc_pkg::*; (
	input  logic     in_valid,
	output logic     in_stall,
	input  in_t      in_data,
	input  logic     q_full,
	output logic     q_push,
	output q_entry_t q_wdata
);

	logic [CHANNELS-1:0][SAMPLE_BITS-1:0] smp;

	// unpack the scan into a channel array
	assign smp[0] = in_data.sample_0;
	assign smp[1] = in_data.sample_1;
	assign smp[2] = in_data.sample_2;
	assign smp[3] = in_data.sample_3;
	assign smp[4] = in_data.sample_4;
	assign smp[5] = in_data.sample_5;
	assign smp[6] = in_data.sample_6;
	assign smp[7] = in_data.sample_7;

	// percent conversion, one constant multiply per channel
	always_comb begin
		q_wdata.mode = in_data.mode;
		for (int i = 0; i < CHANNELS; i++) begin
			q_wdata.pct[i] = pct_of(smp[i]);
		end
	end

	assign in_stall = q_full;
	assign q_push   = in_valid & ~q_full;

endmodule

// ----- src/lsc_fifo.sv -----
// Short queue of classified scans between front and back end.
module lsc_fifo import lsc_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wdata,
	output logic     full,
	input  logic     pop,
	output logic     valid,
	output q_entry_t rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]     cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/lsc_back.sv -----
// Back end: calibration update, per-channel mapping and centroid on a shared divider.
module lsc_back import lsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     q_valid,
	input  q_entry_t q_rdata,
	output logic     q_pop,
	output logic     out_valid,
	input  logic     out_stall,
	output out_t     out_data
);

	back_st_t st_q, st_d;

	logic [PCT_W-1:0]  max_q [CHANNELS];
	logic [PCT_W-1:0]  min_q [CHANNELS];
	logic [CHANNELS-1:0][PCT_W-1:0] pct_q;
	logic [CH_W-1:0]   ch_q;
	logic [SUM_W-1:0]  sum_q;
	logic [WSUM_W-1:0] wsum_q;
	logic [VAL_W-1:0]  v_q;
	logic [POS_W-1:0]  res_pos_q;
	logic              res_found_q;
	logic              out_valid_q;
	out_t              out_q;

	// shared divider
	logic [DIV_W-1:0]        dv_rem_q, dv_den_q;
	logic [QR_W-1:0]         dv_quo_q;
	logic [$clog2(QR_W)-1:0] dv_cnt_q;
	logic                    dv_ge;
	logic [DIV_W-1:0]        dv_rem_n;
	logic [QR_W-1:0]         dv_quo_n;

	// mapping datapath
	logic [PCT_W-1:0] lo, hi, p, c;
	logic [VAL_W-1:0] span;
	logic             empty_rng;
	logic [SUM_W-1:0]  sum_n;
	logic [WSUM_W-1:0] wsum_n;
	logic              last_ch, out_ld;

	assign lo        = min_q[ch_q];
	assign hi        = max_q[ch_q];
	assign p         = pct_q[ch_q];
	assign empty_rng = (hi <= lo);
	assign span      = (cfg.out_max >= cfg.out_min) ? cfg.out_max - cfg.out_min : '0;
	assign c         = (p < lo) ? lo : ((p > hi) ? hi : p);

	assign dv_ge    = (dv_rem_q >= dv_den_q);
	assign dv_rem_n = dv_ge ? dv_rem_q - dv_den_q : dv_rem_q;
	assign dv_quo_n = {dv_quo_q[QR_W-2:0], dv_ge};

	assign sum_n   = sum_q + SUM_W'(v_q);
	assign wsum_n  = wsum_q + WSUM_W'(ch_weight(ch_q) * v_q);
	assign last_ch = (ch_q == CH_W'(CHANNELS - 1));
	assign out_ld  = (st_q == B_OUT) && (!out_valid_q || !out_stall);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state
	always_comb begin
		st_d  = st_q;
		q_pop = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					st_d  = q_rdata.mode ? B_MAP : B_OUT;
				end
			end
			B_MAP:  st_d = empty_rng ? B_ACC : B_DIV;
			B_DIV:  st_d = (dv_cnt_q == '0) ? B_ACC : B_DIV;
			B_ACC: begin
				if (!last_ch) begin
					st_d = B_MAP;
				end else begin
					st_d = (sum_n == '0) ? B_OUT : B_FDIV;
				end
			end
			B_FDIV: st_d = (dv_cnt_q == '0) ? B_OUT : B_FDIV;
			B_OUT:  st_d = out_ld ? B_IDLE : B_OUT;
			default: st_d = B_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				max_q[i] <= '0;
				min_q[i] <= '0;
			end
			pct_q       <= '0;
			ch_q        <= '0;
			sum_q       <= '0;
			wsum_q      <= '0;
			v_q         <= '0;
			res_pos_q   <= '0;
			res_found_q <= 1'b0;
			dv_rem_q    <= '0;
			dv_den_q    <= '0;
			dv_quo_q    <= '0;
			dv_cnt_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			case (st_q)
				B_IDLE: begin
					if (q_valid) begin
						pct_q       <= q_rdata.pct;
						ch_q        <= '0;
						sum_q       <= '0;
						wsum_q      <= '0;
						res_pos_q   <= '0;
						res_found_q <= 1'b0;
						// calibration widens every channel at once
						if (!q_rdata.mode) begin
							for (int i = 0; i < CHANNELS; i++) begin
								if (q_rdata.pct[i] > max_q[i]) begin
									max_q[i] <= q_rdata.pct[i];
								end
								if (q_rdata.pct[i] < min_q[i] || min_q[i] == '0) begin
									min_q[i] <= q_rdata.pct[i];
								end
							end
						end
					end
				end
				B_MAP: begin
					v_q      <= cfg.out_min;
					dv_rem_q <= DIV_W'((c - lo) * span);
					dv_den_q <= DIV_W'(hi - lo) << (VAL_W - 1);
					dv_quo_q <= '0;
					dv_cnt_q <= ($clog2(QR_W))'(VAL_W - 1);
				end
				B_DIV: begin
					dv_rem_q <= dv_rem_n;
					dv_den_q <= dv_den_q >> 1;
					dv_quo_q <= dv_quo_n;
					dv_cnt_q <= dv_cnt_q - 1'b1;
					if (dv_cnt_q == '0) begin
						v_q <= dv_quo_n[VAL_W-1:0] + cfg.out_min;
					end
				end
				B_ACC: begin
					sum_q  <= sum_n;
					wsum_q <= wsum_n;
					ch_q   <= ch_q + 1'b1;
					// start the centroid division
					dv_rem_q <= DIV_W'(wsum_n);
					dv_den_q <= DIV_W'(sum_n) << (QW - 1);
					dv_quo_q <= '0;
					dv_cnt_q <= ($clog2(QR_W))'(QW - 1);
				end
				B_FDIV: begin
					dv_rem_q <= dv_rem_n;
					dv_den_q <= dv_den_q >> 1;
					dv_quo_q <= dv_quo_n;
					dv_cnt_q <= dv_cnt_q - 1'b1;
					if (dv_cnt_q == '0) begin
						res_found_q <= 1'b1;
						res_pos_q   <= (dv_quo_n > QR_W'(POS_LIMIT)) ? POS_W'(POS_LIMIT)
							: dv_quo_n[POS_W-1:0];
					end
				end
				default: ;
			endcase

			// output register
			if (out_ld) begin
				out_valid_q         <= 1'b1;
				out_q.line_position <= res_pos_q;
				out_q.line_found    <= res_found_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> st_q == B_IDLE) else $error("queue popped while busy");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_DIV || st_q == B_FDIV) |-> dv_cnt_q < ($clog2(QR_W))'(QR_W))
		else $error("divider step count out of range");
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld && !res_found_q |-> res_pos_q == '0)
		else $error("position nonzero without line");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld && res_found_q |-> res_pos_q <= POS_W'(POS_LIMIT))
		else $error("position above limit");

endmodule

// ----- src/line_sensor_calibrated_position.sv -----
// Top level of the calibrated reflectance line sensor.
// Input channel in_valid/in_stall/in_data carries one scan: mode and eight
// 12-bit samples. Mode 0 widens the stored per-channel min/max percent and
// returns position 0, not found. Mode 1 maps each channel onto
// out_min..out_max and returns the weighted centroid 0..700 and a found flag.
// Output channel out_valid/out_stall/out_data gives exactly one result per scan.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes out_min (index 0)
// and out_max (index 1); cfg_ready is always high.
// Sequence: a calibrate scan goes from idle straight to the output load; a
// measure scan runs map, divider steps and accumulate for each channel (a
// channel with an empty min/max range skips the divider), then the final
// divider steps for the QW = 10 centroid quotient bits, skipped when the sum
// is zero, and the output load. One shared restoring divider gives one
// quotient bit a cycle; scans are processed one at a time.
// A small queue holds accepted scans, so in_stall rises only when it is full.
// When the receiver stalls, the result holds in the output register and the
// back end finishes the next scan, then waits.
// Reset clears the queue, calibration (all channels unset) and sets
// out_min = 0, out_max = 1000.
module line_sensor_calibrated_position import lsc_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data
);

	cfg_t     cfg_q;
	logic     q_full, q_push, q_pop, q_valid;
	q_entry_t q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_min <= VAL_W'(0);
			cfg_q.out_max <= VAL_W'(1000);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OUT_MIN: cfg_q.out_min <= cfg_data;
				CFG_OUT_MAX: cfg_q.out_max <= cfg_data;
				default: ;
			endcase
		end
	end

	lsc_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	lsc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	lsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- tb/line_sensor_calibrated_position_test.sv -----
// Self-checking testbench of the calibrated reflectance line sensor.
module line_sensor_calibrated_position_test;
	import lsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	in_t in_data;
	out_t out_data;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0] cfg_data;

	line_sensor_calibrated_position u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [9:0] lim_lo, lim_hi;
	logic [6:0] cal_max [CHANNELS];
	logic [6:0] cal_min [CHANNELS];
	out_t pending_positions [$];
	int mismatches, results_seen, scans_sent, measure_scans, found_count;
	bit run_fail;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("Timeout with %0d results outstanding", pending_positions.size());
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [6:0] scale_pct(logic [11:0] raw);
		int unsigned r;
		r = raw;
		return 7'((r * 100) >> 12);
	endfunction

	function automatic logic [11:0] raw_of(in_t s, int ch);
		logic [11:0] r [8];
		r = '{s.sample_0, s.sample_1, s.sample_2, s.sample_3,
			s.sample_4, s.sample_5, s.sample_6, s.sample_7};
		return r[ch];
	endfunction

	// work out the result of one scan and update calibration
	function automatic out_t predict_position(in_t s);
		out_t r;
		int unsigned p, lo, hi, span, c, v, total, weighted, pos;
		r = '0;
		total = 0;
		weighted = 0;
		for (int i = 0; i < CHANNELS; i++) begin
			p = scale_pct(raw_of(s, i));
			lo = cal_min[i];
			hi = cal_max[i];
			if (!s.mode) begin
				if (p > hi) cal_max[i] = 7'(p);
				if (p < lo || lo == 0) cal_min[i] = 7'(p);
			end else begin
				if (hi <= lo) v = lim_lo;
				else begin
					span = (lim_hi >= lim_lo) ? lim_hi - lim_lo : 0;
					c = p < lo ? lo : p;
					if (c > hi) c = hi;
					v = (c - lo) * span / (hi - lo) + lim_lo;
				end
				total += v;
				weighted += 100 * i * v;
			end
		end
		if (s.mode && total != 0) begin
			pos = weighted / total;
			if (pos > 1023) pos = 1023;
			r.line_position = 10'(pos);
			r.line_found = 1'b1;
		end
		return r;
	endfunction

	// check every result transfer against the oldest expectation
	always @(posedge clk) begin
		out_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (out_data.line_found) found_count++;
			if (pending_positions.size() == 0) begin
				run_fail = 1;
				$display("Unexpected result %p", out_data);
			end else begin
				exp_r = pending_positions.pop_front();
				if (out_data !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected pos %0d found %0d, got pos %0d found %0d",
							exp_r.line_position, exp_r.line_found,
							out_data.line_position, out_data.line_found);
				end
			end
		end
	end

	// receiver stalls a random number of cycles per result
	initial begin
		int w;
		out_stall = 0;
		@(negedge clk);
		forever begin
			w = $urandom_range(0, 5);
			out_stall = (w != 0);
			repeat (w) @(negedge clk);
			out_stall = 0;
			@(negedge clk);
			while (!(out_valid && !out_stall)) begin
				@(posedge clk);
				@(negedge clk);
			end
		end
	end

	task automatic send_scan(in_t s);
		repeat ($urandom_range(0, 5)) @(negedge clk);
		in_data = s;
		in_valid = 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_positions.push_back(predict_position(s));
		scans_sent++;
		if (s.mode) measure_scans++;
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic drain;
		while (pending_positions.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_limit(cfg_idx_t idx, logic [9:0] val);
		drain();
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_OUT_MIN) lim_lo = val; else lim_hi = val;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic in_t make_scan(bit m, logic [11:0] a [8]);
		in_t s;
		s.mode = m;
		{s.sample_0, s.sample_1, s.sample_2, s.sample_3,
			s.sample_4, s.sample_5, s.sample_6, s.sample_7} =
			{a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7]};
		return s;
	endfunction

	function automatic in_t rand_scan(bit m, int lo, int hi);
		logic [11:0] a [8];
		foreach (a[i]) a[i] = 12'($urandom_range(lo, hi));
		return make_scan(m, a);
	endfunction

	// uncalibrated measure, extremes, calibration, line on each channel
	task automatic test_directed;
		logic [11:0] a [8];
		send_scan(rand_scan(1, 0, 4095));
		send_scan(make_scan(0, '{default: 12'd0}));
		send_scan(make_scan(0, '{default: 12'hFFF}));
		send_scan(make_scan(1, '{default: 12'hFFF}));
		send_scan(make_scan(0, '{default: 12'd2000}));
		send_scan(make_scan(0, '{default: 12'd100}));
		send_scan(make_scan(1, '{default: 12'd0}));
		for (int k = 0; k < CHANNELS; k++) begin
			a = '{default: 12'd0};
			a[k] = 12'hFFF;
			send_scan(make_scan(1, a));
		end
		send_scan(make_scan(1, '{12'hAAA, 12'h555, 12'hAAA, 12'h555,
			12'hAAA, 12'h555, 12'hAAA, 12'h555}));
	endtask

	// output range settings incl. inverted and extremes
	task automatic test_ranges;
		int lo_set [5] = '{0, 1000, 1023, 500, 0};
		int hi_set [5] = '{1023, 0, 1023, 100, 1000};
		for (int k = 0; k < 5; k++) begin
			write_limit(CFG_OUT_MIN, 10'(lo_set[k]));
			write_limit(CFG_OUT_MAX, 10'(hi_set[k]));
			repeat (40) send_scan(rand_scan(1, 0, 4095));
			send_scan(make_scan(1, '{default: 12'd0}));
		end
	endtask

	// random: mostly measure, with occasional recalibration
	task automatic test_random;
		for (int n = 0; n < 1200; n++) begin
			if ($urandom_range(0, 9) == 0) send_scan(rand_scan(0, 0, 4095));
			else if ($urandom_range(0, 3) == 0) send_scan(rand_scan(1, 0, 4095));
			else send_scan(rand_scan(1, $urandom_range(0, 2000), 4095));
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = CFG_OUT_MIN;
		cfg_data = '0;
		lim_lo = 10'd0;
		lim_hi = 10'd1000;
		foreach (cal_max[i]) begin
			cal_max[i] = '0;
			cal_min[i] = '0;
		end
		repeat (9) @(negedge clk);
		arst_n = 1;
		test_directed();
		test_ranges();
		test_random();
		drain();
		$display("Sent %0d scans (%0d measure), checked %0d results, %0d mismatches",
			scans_sent, measure_scans, results_seen, mismatches);
		$display("Line found in %0d results, across calibration and output range changes",
			found_count);
		if (!run_fail && mismatches == 0 && pending_positions.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ----- files.f -----
src/lsc_pkg.sv
src/lsc_front.sv
src/lsc_fifo.sv
src/lsc_back.sv
src/line_sensor_calibrated_position.sv
tb/line_sensor_calibrated_position_test.sv
